FILE: src/hsl_pkg.sv
// Shared types, constants and helper functions of the HSL to RGB converter.
package hsl_pkg;

    localparam int unsigned LvlW   = 17;
    localparam int unsigned HueW   = 16;
    localparam int unsigned PosW   = 18;
    localparam int unsigned FacW   = 16;
    localparam int unsigned WideW  = 33;
    localparam int unsigned ProdW  = WideW + FacW;
    localparam int unsigned ChanW  = 8;
    localparam int unsigned NumCh  = 3;

    localparam logic [LvlW-1:0] OneQ16  = 17'd65536;
    localparam logic [LvlW-1:0] HalfQ16 = 17'd32768;
    localparam logic [PosW:0]   Turn3   = 19'd196608;
    localparam logic [PosW:0]   Third3  = 19'd65536;
    localparam logic [PosW:0]   TwoThd3 = 19'd131072;

    localparam int unsigned ChRed   = 0;
    localparam int unsigned ChGreen = 1;
    localparam int unsigned ChBlue  = 2;

    typedef struct packed {
        logic [HueW-1:0] hue_turn;
        logic [LvlW-1:0] saturation;
        logic [LvlW-1:0] lightness;
        logic [LvlW-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [LvlW-1:0]                l;
        logic [LvlW-1:0]                s;
        logic [WideW-1:0]               ls;
        logic [NumCh-1:0][FacW-1:0]     fac;
        logic [ChanW-1:0]               grey;
        logic [ChanW-1:0]               alpha;
        logic                           s_zero;
    } t_prep;

    typedef struct packed {
        logic [WideW-1:0]               p;
        logic [WideW-1:0]               diff;
        logic [NumCh-1:0][FacW-1:0]     fac;
        logic [ChanW-1:0]               grey;
        logic [ChanW-1:0]               alpha;
        logic                           s_zero;
    } t_lvl;

    typedef struct packed {
        logic [ChanW-1:0] grey;
        logic [ChanW-1:0] alpha;
        logic             s_zero;
    } t_side;

    function automatic logic [LvlW-1:0] clamp_unit(input logic [LvlW-1:0] v);
        return (v > OneQ16) ? OneQ16 : v;
    endfunction

    // Wraps a hue position that is below two turns back into one turn.
    function automatic logic [PosW-1:0] wrap_pos(input logic [PosW:0] v);
        logic [PosW:0] w;
        w = (v >= Turn3) ? (v - Turn3) : v;
        return w[PosW-1:0];
    endfunction

    // Weight of q against p along the ramp, in units of 1/32768.
    function automatic logic [FacW-1:0] ramp_fac(input logic [PosW-1:0] t);
        logic [PosW:0] tx;
        logic [PosW:0] fall;
        logic [FacW-1:0] f;
        tx   = {1'b0, t};
        fall = TwoThd3 - tx;
        if (tx < 19'd32768) begin
            f = tx[FacW-1:0];
        end else if (tx < 19'd98304) begin
            f = 16'd32768;
        end else if (tx < TwoThd3) begin
            f = fall[FacW-1:0];
        end else begin
            f = '0;
        end
        return f;
    endfunction

endpackage

FILE: src/hsl_if.sv
// Valid/ready channel interfaces for input pixels and output pixels.
interface hsl_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue_turn;
    logic [16:0] saturation;
    logic [16:0] lightness;
    logic [16:0] alpha_in;

    modport source (output valid, hue_turn, saturation, lightness, alpha_in, input ready);
    modport sink   (input valid, hue_turn, saturation, lightness, alpha_in, output ready);
endinterface

interface hsl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

FILE: src/hsl_to_rgb_convert_top.sv
// Top level of the HSLA to RGBA pixel converter pipeline.
//
//   Channel  Direction  Contents
//   i_pix    in         hue_turn, saturation, lightness, alpha_in
//   o_pix    out        red, green, blue, alpha_out
//
// One item per cycle is accepted unless a stalled output has filled the stages; each passes from input to output
// through the prepare, level, multiply and output register stages.
// Reset clears only the stage valid bits, as the conversion keeps no state.
// A stalled output holds the full stages behind it, while empty stages keep
// taking items, so no bubble holds up the input.
module hsl_to_rgb_convert_top
    import hsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsl_in_if.sink     i_pix,
    hsl_out_if.source  o_pix
);

    localparam int unsigned NumStg = 4;

    logic [NumStg-1:0]       r_vld;
    logic [NumStg-1:0]       en;
    t_pix_in                 pix;
    t_prep                   prep;
    t_lvl                    lvl;
    t_side                   r_side;
    logic [NumCh-1:0][ChanW-1:0] chan;
    logic [ChanW-1:0]        r_red;
    logic [ChanW-1:0]        r_green;
    logic [ChanW-1:0]        r_blue;
    logic [ChanW-1:0]        r_alpha;

    always_comb begin
        en[NumStg-1] = !r_vld[NumStg-1] || o_pix.ready;
        for (int k = NumStg - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    always_comb begin
        pix.hue_turn   = i_pix.hue_turn;
        pix.saturation = i_pix.saturation;
        pix.lightness  = i_pix.lightness;
        pix.alpha_in   = i_pix.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    hsl_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_pix  (pix),
        .o_prep (prep)
    );

    hsl_level u_level (
        .i_clk  (i_clk),
        .i_en   (en[1]),
        .i_prep (prep),
        .o_lvl  (lvl)
    );

    hsl_ramp u_ramp_red (
        .i_clk  (i_clk),
        .i_en   (en[2]),
        .i_p    (lvl.p),
        .i_diff (lvl.diff),
        .i_fac  (lvl.fac[ChRed]),
        .o_chan (chan[ChRed])
    );

    hsl_ramp u_ramp_green (
        .i_clk  (i_clk),
        .i_en   (en[2]),
        .i_p    (lvl.p),
        .i_diff (lvl.diff),
        .i_fac  (lvl.fac[ChGreen]),
        .o_chan (chan[ChGreen])
    );

    hsl_ramp u_ramp_blue (
        .i_clk  (i_clk),
        .i_en   (en[2]),
        .i_p    (lvl.p),
        .i_diff (lvl.diff),
        .i_fac  (lvl.fac[ChBlue]),
        .o_chan (chan[ChBlue])
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_side.grey   <= lvl.grey;
            r_side.alpha  <= lvl.alpha;
            r_side.s_zero <= lvl.s_zero;
        end
        if (en[3]) begin
            r_red   <= r_side.s_zero ? r_side.grey : chan[ChRed];
            r_green <= r_side.s_zero ? r_side.grey : chan[ChGreen];
            r_blue  <= r_side.s_zero ? r_side.grey : chan[ChBlue];
            r_alpha <= r_side.alpha;
        end
    end

    assign o_pix.valid     = r_vld[NumStg-1];
    assign o_pix.red       = r_red;
    assign o_pix.green     = r_green;
    assign o_pix.blue      = r_blue;
    assign o_pix.alpha_out = r_alpha;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !en[2] |=> r_vld[2] && r_vld[3])
        else $error("item lost from the multiply stage during a stall");

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && en[3] && r_side.s_zero |=>
            (o_pix.red == o_pix.green) && (o_pix.green == o_pix.blue))
        else $error("grey item left with unequal channels");

endmodule

FILE: src/hsl_prep.sv
// First stage: clamping, l*s product, hue positions, grey and alpha values.
module hsl_prep
    import hsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_pix_in i_pix,
    output t_prep   o_prep
);

    t_prep             r_prep;
    t_prep             n_prep;
    logic [LvlW-1:0]   l_c;
    logic [LvlW-1:0]   s_c;
    logic [LvlW-1:0]   a_c;
    logic [2*LvlW-1:0] ls_full;
    logic [PosW-1:0]   h3;
    logic [24:0]       l255;
    logic [24:0]       a255;
    logic [24:0]       grey_sum;

    always_comb begin
        l_c      = clamp_unit(i_pix.lightness);
        s_c      = clamp_unit(i_pix.saturation);
        a_c      = clamp_unit(i_pix.alpha_in);
        ls_full  = l_c * s_c;
        h3       = {1'b0, i_pix.hue_turn, 1'b0} + {2'b00, i_pix.hue_turn};
        l255     = {l_c, 8'd0} - {8'd0, l_c};
        a255     = {a_c, 8'd0} - {8'd0, a_c};
        grey_sum = l255 + 25'd32768;

        n_prep               = '0;
        n_prep.l             = l_c;
        n_prep.s             = s_c;
        n_prep.ls            = ls_full[WideW-1:0];
        n_prep.fac[ChRed]    = ramp_fac(wrap_pos({1'b0, h3} + Third3));
        n_prep.fac[ChGreen]  = ramp_fac(h3);
        n_prep.fac[ChBlue]   = ramp_fac(wrap_pos({1'b0, h3} + TwoThd3));
        n_prep.grey          = grey_sum[23:16];
        n_prep.alpha         = a255[23:16];
        n_prep.s_zero        = (s_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

FILE: src/hsl_level.sv
// Second stage: the two levels q and p, passed on as p and q - p.
module hsl_level
    import hsl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_prep i_prep,
    output t_lvl  o_lvl
);

    t_lvl        r_lvl;
    t_lvl        n_lvl;
    logic [33:0] q;
    logic [33:0] l2;
    logic [33:0] p;
    logic [33:0] diff;

    always_comb begin
        if (i_prep.l <= HalfQ16) begin
            q = {1'b0, i_prep.l, 16'd0} + {1'b0, i_prep.ls};
        end else begin
            q = {({1'b0, i_prep.l} + {1'b0, i_prep.s}), 16'd0} - {1'b0, i_prep.ls};
        end
        l2   = {i_prep.l, 17'd0};
        p    = l2 - q;
        diff = {q[32:0], 1'b0} - l2;

        n_lvl        = '0;
        n_lvl.p      = p[WideW-1:0];
        n_lvl.diff   = diff[WideW-1:0];
        n_lvl.fac    = i_prep.fac;
        n_lvl.grey   = i_prep.grey;
        n_lvl.alpha  = i_prep.alpha;
        n_lvl.s_zero = i_prep.s_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lvl <= n_lvl;
        end
    end

    assign o_lvl = r_lvl;

endmodule

FILE: src/hsl_ramp.sv
// Third stage of one channel: ramp product, then level scaling and rounding.
module hsl_ramp
    import hsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WideW-1:0] i_p,
    input  logic [WideW-1:0] i_diff,
    input  logic [FacW-1:0]  i_fac,
    output logic [ChanW-1:0] o_chan
);

    logic [ProdW-1:0] r_prod;
    logic [WideW-1:0] r_p;
    logic [47:0]      lvl;
    logic [55:0]      scaled;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= ProdW'(i_diff) * ProdW'(i_fac);
            r_p    <= i_p;
        end
    end

    // The level is scaled by 2^47; times 255 plus one half, then the top bits.
    always_comb begin
        lvl    = {r_p[32:0], 15'd0} + r_prod[47:0];
        scaled = {lvl, 8'd0} - {8'd0, lvl} + 56'h00_4000_0000_0000;
        o_chan = scaled[54:47];
    end

endmodule

FILE: dv/hsl_rgba_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the HSL to RGB converter: predicts each RGBA result and compares it.
module hsl_rgba_checker
    import hsl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hsl_in_if    i_in_mon,
    hsl_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha_out;
    } t_rgba;

    t_rgba rgba_pending[$];
    int    mismatch_count = 0;

    function automatic logic [63:0] level_clamped(input logic [LvlW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'd65536) ? 64'd65536 : w;
    endfunction

    // The position is in units of 1/196608 of a turn; lo and hi are scaled by 2^32.
    function automatic logic [ChanW-1:0] ramp_to_byte(input logic [63:0] pos,
                                                       input logic [63:0] lo,
                                                       input logic [63:0] hi);
        logic [63:0] span;
        logic [63:0] lvl;
        logic [63:0] scaled;
        span = hi - lo;
        if (pos < 64'd32768) begin
            lvl = (lo << 15) + span * pos;
        end else if (pos < 64'd98304) begin
            lvl = hi << 15;
        end else if (pos < 64'd131072) begin
            lvl = (lo << 15) + span * (64'd131072 - pos);
        end else begin
            lvl = lo << 15;
        end
        scaled = (lvl * 64'd255 + (64'd1 << 46)) >> 47;
        return scaled[ChanW-1:0];
    endfunction

    function automatic t_rgba rgba_from_hsla(input t_pix_in px);
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] l;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] h3;
        logic [63:0] grey;
        logic [63:0] alpha;
        t_rgba       res;
        h = 64'(px.hue_turn);
        s = level_clamped(px.saturation);
        l = level_clamped(px.lightness);
        a = level_clamped(px.alpha_in);
        if (s == 64'd0) begin
            grey      = (l * 64'd255 + 64'd32768) >> 16;
            res.red   = grey[ChanW-1:0];
            res.green = grey[ChanW-1:0];
            res.blue  = grey[ChanW-1:0];
        end else begin
            if (l <= 64'd32768) begin
                q = l * (64'd65536 + s);
            end else begin
                q = l * 64'd65536 + s * 64'd65536 - l * s;
            end
            p         = 64'd2 * l * 64'd65536 - q;
            h3        = 64'd3 * h;
            res.red   = ramp_to_byte((h3 + 64'd65536) % 64'd196608, p, q);
            res.green = ramp_to_byte(h3 % 64'd196608, p, q);
            res.blue  = ramp_to_byte((h3 + 64'd131072) % 64'd196608, p, q);
        end
        alpha         = (a * 64'd255) >> 16;
        res.alpha_out = alpha[ChanW-1:0];
        return res;
    endfunction

    task automatic check_byte(input string name, input logic [ChanW-1:0] exp_val,
                              input logic [ChanW-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_in px;
        t_rgba   want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                px.hue_turn   = i_in_mon.hue_turn;
                px.saturation = i_in_mon.saturation;
                px.lightness  = i_in_mon.lightness;
                px.alpha_in   = i_in_mon.alpha_in;
                rgba_pending.push_back(rgba_from_hsla(px));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (rgba_pending.size() == 0) begin
                    $error("Result item arrived with no pixel outstanding.");
                    mismatch_count++;
                end else begin
                    want = rgba_pending.pop_front();
                    check_byte("red", want.red, i_out_mon.red);
                    check_byte("green", want.green, i_out_mon.green);
                    check_byte("blue", want.blue, i_out_mon.blue);
                    check_byte("alpha_out", want.alpha_out, i_out_mon.alpha_out);
                end
            end
        end
        o_pending    <= rgba_pending.size();
        o_fail_count <= mismatch_count;
    end

endmodule

FILE: dv/tb_hsl_to_rgb_convert_top.sv
`timescale 1ns / 100ps
// Top testbench of the HSL to RGB converter: clock, reset, pixel stimulus and verdict.
module tb_hsl_to_rgb_convert_top
    import hsl_pkg::*;
();

    localparam int CycleLimit = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct = 23;
    int   recv_idle_pct = 47;
    int   cycle_count   = 0;
    int   fail_count;
    int   pending_count;

    hsl_in_if  pix_in ();
    hsl_out_if pix_out ();

    hsl_to_rgb_convert_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    hsl_rgba_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (pix_in),
        .i_out_mon    (pix_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[hsl_to_rgb_convert_top] ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [HueW-1:0] h, input logic [LvlW-1:0] s,
                              input logic [LvlW-1:0] l, input logic [LvlW-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue_turn   <= h;
        pix_in.saturation <= s;
        pix_in.lightness  <= l;
        pix_in.alpha_in   <= a;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    function automatic logic [LvlW-1:0] random_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 25) begin
            return LvlW'($urandom_range(131071));
        end else if (pick < 35) begin
            return OneQ16;
        end
        return LvlW'($urandom_range(65536));
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(HueW'($urandom_range(65535)), random_level(), random_level(),
                       random_level());
        end
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        pix_in.valid      <= 1'b0;
        pix_in.hue_turn   <= '0;
        pix_in.saturation <= '0;
        pix_in.lightness  <= '0;
        pix_in.alpha_in   <= '0;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Grey path, extremes of every field and levels above one.
        send_pixel(16'd0, 17'd0, 17'd0, 17'd0);
        send_pixel(16'd12345, 17'd0, 17'd65536, 17'd65536);
        send_pixel(16'd65535, 17'd0, 17'd32768, 17'd131071);
        send_pixel(16'd40000, 17'd0, 17'd131071, 17'd65535);
        send_pixel(16'd0, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd65535, 17'd65536, 17'd32768, 17'd1);
        send_pixel(16'd21845, 17'd131071, 17'd32768, 17'd32768);
        send_pixel(16'd43690, 17'd1, 17'd32768, 17'd255);
        // Hue positions close to the ramp corners, on both sides of some of them.
        send_pixel(16'd10922, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd10923, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd32767, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd32768, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd43691, 17'd65536, 17'd32768, 17'd65536);
        send_pixel(16'd54613, 17'd65536, 17'd32768, 17'd65536);
        // Lightness around one half and at both ends with colour present.
        send_pixel(16'd5000, 17'd40000, 17'd32768, 17'd30000);
        send_pixel(16'd5000, 17'd40000, 17'd32769, 17'd30000);
        send_pixel(16'd25000, 17'd65535, 17'd0, 17'd65536);
        send_pixel(16'd25000, 17'd65535, 17'd65536, 17'd0);
        send_pixel(16'd50000, 17'd99999, 17'd131071, 17'd65536);
        send_pixel(16'd60000, 17'd30000, 17'd1, 17'd65536);
        send_pixel(16'd3000, 17'd30000, 17'd65535, 17'd65536);

        wait_drained();
        send_random(150);

        send_idle_pct = 47;
        recv_idle_pct = 23;
        send_random(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(150);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[hsl_to_rgb_convert_top] OK");
        end else begin
            $display("[hsl_to_rgb_convert_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/hsl_pkg.sv
src/hsl_if.sv
src/hsl_prep.sv
src/hsl_level.sv
src/hsl_ramp.sv
src/hsl_to_rgb_convert_top.sv
dv/hsl_rgba_checker.sv
dv/tb_hsl_to_rgb_convert_top.sv
